### src/iee_pkg.sv
// Shared types and constants for the infix expression evaluator.
package iee_pkg;

	localparam int STACK_DEPTH_DEF   = 4;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int VALUE_W           = 64;

	// Operator codes as held on the operator stack
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// Character codes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [63:0] SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SMIN_MAG = 64'h8000_0000_0000_0000;

	// Datapath commands issued by the controller
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_DIGIT,     // accumulate a digit into the literal
		CMD_END_LIT,   // push the literal if one is open
		CMD_PUSH_OP,   // push the operator held in the command
		CMD_RED_START, // pop operator and load operands
		CMD_MUL_LO,    // first partial product pass
		CMD_MUL_HI,    // second partial product pass
		CMD_MUL_FIN,   // add the remaining partial products into the product
		CMD_DIV_STEP,  // one divider step
		CMD_RED_WRITE, // write result onto value stack
		CMD_FINISH,    // latch result and clear
		CMD_CLEAR      // never issued by the controller; the datapath takes no action on it
	} cmd_e_t;

	typedef struct packed {
		cmd_e_t     cmd;
		logic [7:0] ch;
		op_t        op;
	} cmd_t;

	typedef struct packed {
		logic       op_empty;
		op_t        op_top;
		logic       red_valid; // reduction has two operands
		op_t        red_op;
		logic       div_done;
	} stat_t;

endpackage

### src/iee_datapath.sv
// Datapath: stacks, literal accumulator, arithmetic unit and flags.
module iee_datapath #(
	parameter int STACK_DEPTH   = iee_pkg::STACK_DEPTH_DEF,
	parameter int FRACTION_BITS = iee_pkg::FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  iee_pkg::cmd_t       cmd,
	output iee_pkg::stat_t      stat,
	output logic signed [63:0]  res_value,
	output logic                res_ovf,
	output logic                res_div0,
	output logic                res_mal
);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int FB = FRACTION_BITS;
	localparam int DIV_STEPS = 128;
	localparam int DCW = $clog2(DIV_STEPS);

	logic [63:0]        vstk_q [STACK_DEPTH];
	iee_pkg::op_t       ostk_q [STACK_DEPTH];
	logic [CW-1:0]      vcnt_q, ocnt_q;
	logic [63:0]        lit_q;
	logic               inlit_q;
	logic               ovf_q, div0_q, mal_q;

	// reduction working registers
	iee_pkg::op_t       rop_q;
	logic [63:0]        lhs_q, rhs_q;
	logic               neg_q;
	logic [127:0]       prod_q;
	logic [63:0]        pp_q [2];
	logic [127:0]       num_q;
	logic [127:0]       quo_q;
	logic [63:0]        rem_q;
	logic [DCW-1:0]     dcnt_q;
	logic               dbusy_q;

	// magnitudes of the stack top pair
	logic [63:0] a_v, b_v, ma, mb;
	assign a_v = vstk_q[AW'(vcnt_q - CW'(2))];
	assign b_v = vstk_q[AW'(vcnt_q - CW'(1))];
	assign ma  = a_v[63] ? (64'd0 - a_v) : a_v;
	assign mb  = b_v[63] ? (64'd0 - b_v) : b_v;

	// status back to the controller
	always_comb begin
		stat.op_empty  = (ocnt_q == '0);
		stat.op_top    = ostk_q[AW'(ocnt_q - CW'(1))];
		stat.red_valid = (vcnt_q >= CW'(2));
		stat.red_op    = rop_q;
		stat.div_done  = !dbusy_q || (dcnt_q == '0);
	end

	// literal digit arithmetic: overflow when ten times the literal plus the digit
	// leaves the positive range
	logic [63:0] dig_v, lit_base, lit_next;
	logic [67:0] lit_wide;
	logic        lit_ovf;
	assign dig_v    = 64'(cmd.ch - iee_pkg::CH_ZERO) << FB;
	assign lit_base = inlit_q ? lit_q : 64'd0;
	assign lit_wide = ({4'd0, lit_base} << 3) + ({4'd0, lit_base} << 1) + {4'd0, dig_v};
	assign lit_ovf  = lit_wide > {4'd0, iee_pkg::SMAX};
	assign lit_next = lit_wide[63:0];

	// add / subtract with saturation
	logic [63:0] sum_v, bx;
	logic        add_ovf;
	assign bx      = (rop_q == iee_pkg::OP_SUB) ? ~rhs_q : rhs_q;
	assign sum_v   = (rop_q == iee_pkg::OP_SUB) ? lhs_q - rhs_q : lhs_q + rhs_q;
	assign add_ovf = (lhs_q[63] == bx[63]) && (sum_v[63] != lhs_q[63]);

	// saturating conversion of a 128-bit magnitude
	function automatic logic [64:0] from_mag(input logic neg, input logic [127:0] m);
		logic [64:0] r;
		if (!neg) begin
			if (m[127:64] != '0 || m[63:0] > iee_pkg::SMAX) r = {1'b1, iee_pkg::SMAX};
			else r = {1'b0, m[63:0]};
		end else begin
			if (m[127:64] != '0 || m[63:0] > iee_pkg::SMIN_MAG) r = {1'b1, iee_pkg::SMIN_MAG};
			else r = {1'b0, 64'd0 - m[63:0]};
		end
		return r;
	endfunction

	// divider step: restoring, one bit per cycle
	logic [64:0] rsh;
	logic        dsub;
	assign rsh  = {rem_q, num_q[127]};
	assign dsub = rsh >= {1'b0, rhs_q};

	logic [127:0] prod_shift;
	logic [64:0]  mul_res, div_res;
	assign prod_shift = prod_q >> FB;
	assign mul_res    = from_mag(neg_q, prod_shift);
	assign div_res    = from_mag(neg_q, quo_q);

	// reduction result and its overflow
	logic [63:0] red_res;
	logic        red_ovf;
	always_comb begin
		red_res = sum_v;
		red_ovf = 1'b0;
		unique case (rop_q)
			iee_pkg::OP_ADD, iee_pkg::OP_SUB: begin
				if (add_ovf) begin
					red_ovf = 1'b1;
					red_res = lhs_q[63] ? iee_pkg::SMIN_MAG : iee_pkg::SMAX;
				end else red_res = sum_v;
			end
			iee_pkg::OP_MUL: begin
				red_ovf = mul_res[64];
				red_res = mul_res[63:0];
			end
			iee_pkg::OP_DIV: begin
				if (rhs_q == '0) begin
					red_res = (lhs_q == '0) ? 64'd0 :
						(lhs_q[63] ? iee_pkg::SMIN_MAG : iee_pkg::SMAX);
				end else begin
					red_ovf = div_res[64];
					red_res = div_res[63:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q  <= '0;
			ocnt_q  <= '0;
			lit_q   <= '0;
			inlit_q <= 1'b0;
			ovf_q   <= 1'b0;
			div0_q  <= 1'b0;
			mal_q   <= 1'b0;
			dbusy_q <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			unique case (cmd.cmd)
				iee_pkg::CMD_DIGIT: begin
					inlit_q <= 1'b1;
					if (lit_ovf) begin
						ovf_q <= 1'b1;
						lit_q <= iee_pkg::SMAX;
					end else begin
						lit_q <= lit_next;
					end
				end
				iee_pkg::CMD_END_LIT: begin
					if (inlit_q) begin
						if (vcnt_q >= CW'(STACK_DEPTH)) mal_q <= 1'b1;
						else begin
							vstk_q[AW'(vcnt_q)] <= lit_q;
							vcnt_q <= vcnt_q + CW'(1);
						end
						inlit_q <= 1'b0;
						lit_q   <= '0;
					end
				end
				iee_pkg::CMD_PUSH_OP: begin
					if (ocnt_q >= CW'(STACK_DEPTH)) mal_q <= 1'b1;
					else begin
						ostk_q[AW'(ocnt_q)] <= cmd.op;
						ocnt_q <= ocnt_q + CW'(1);
					end
				end
				iee_pkg::CMD_RED_START: begin
					rop_q  <= stat.op_top;
					ocnt_q <= ocnt_q - CW'(1);
					if (vcnt_q < CW'(2)) mal_q <= 1'b1;
					else begin
						rhs_q  <= (stat.op_top == iee_pkg::OP_DIV ||
							stat.op_top == iee_pkg::OP_MUL) ? mb : b_v;
						num_q  <= {ma >> (64 - FB), ma << FB} ;
						neg_q  <= a_v[63] != b_v[63];
						vcnt_q <= vcnt_q - CW'(2);
						rem_q  <= '0;
						quo_q  <= '0;
						lhs_q  <= (stat.op_top == iee_pkg::OP_MUL) ? ma : a_v;
						dcnt_q <= '1;
						dbusy_q <= (stat.op_top == iee_pkg::OP_DIV) && (mb != '0);
						if (stat.op_top == iee_pkg::OP_DIV && mb == '0) begin
							div0_q <= 1'b1;
						end
					end
				end
				iee_pkg::CMD_MUL_LO: begin
					pp_q[0] <= lhs_q[31:0] * rhs_q[31:0];
					pp_q[1] <= lhs_q[31:0] * rhs_q[63:32];
				end
				iee_pkg::CMD_MUL_HI: begin
					prod_q  <= {64'd0, pp_q[0]} + ({64'd0, pp_q[1]} << 32);
					pp_q[0] <= lhs_q[63:32] * rhs_q[31:0];
					pp_q[1] <= lhs_q[63:32] * rhs_q[63:32];
				end
				iee_pkg::CMD_MUL_FIN: begin
					prod_q <= prod_q + ({64'd0, pp_q[0]} << 32) + ({pp_q[1], 64'd0});
				end
				iee_pkg::CMD_DIV_STEP: begin
					num_q <= num_q << 1;
					if (dsub) begin
						rem_q <= 64'(rsh - {1'b0, rhs_q});
						quo_q <= {quo_q[126:0], 1'b1};
					end else begin
						rem_q <= rsh[63:0];
						quo_q <= {quo_q[126:0], 1'b0};
					end
					dcnt_q <= dcnt_q - DCW'(1);
					if (dcnt_q == '0) dbusy_q <= 1'b0;
				end
				iee_pkg::CMD_RED_WRITE: begin
					if (red_ovf) ovf_q <= 1'b1;
					vstk_q[AW'(vcnt_q)] <= red_res;
					vcnt_q <= vcnt_q + CW'(1);
				end
				iee_pkg::CMD_FINISH: begin
					res_value <= (vcnt_q == '0) ? 64'sd0 : b_v;
					res_ovf   <= ovf_q;
					res_div0  <= div0_q;
					res_mal   <= mal_q || (vcnt_q == '0);
					vcnt_q  <= '0;
					ocnt_q  <= '0;
					lit_q   <= '0;
					inlit_q <= 1'b0;
					ovf_q   <= 1'b0;
					div0_q  <= 1'b0;
					mal_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

### src/iee_ctrl.sv
// Controller: sequences character handling, reductions and result output.
module iee_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      character,
	input  logic            last,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  iee_pkg::stat_t  stat,
	output iee_pkg::cmd_t   cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_ENDLIT, S_CHECK, S_RSTART, S_MLO, S_MHI, S_MFIN,
		S_DIV, S_RWRITE, S_FLUSH, S_FIN
	} state_t;

	state_t        state_q;
	logic [7:0]    ch_q;
	logic          last_q;
	logic          isop_q;
	iee_pkg::op_t  op_q;
	logic          flush_q;
	logic          out_valid_q;

	// result register is free when empty or being taken this cycle
	logic fin_ok;
	assign fin_ok = !out_valid_q || out_ready;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// decode of the incoming character
	logic         is_dig, is_op;
	iee_pkg::op_t dec_op;
	always_comb begin
		is_dig = character >= iee_pkg::CH_ZERO && character <= iee_pkg::CH_NINE;
		is_op  = 1'b1;
		dec_op = iee_pkg::OP_ADD;
		unique case (character)
			iee_pkg::CH_PLUS:  dec_op = iee_pkg::OP_ADD;
			iee_pkg::CH_MINUS: dec_op = iee_pkg::OP_SUB;
			iee_pkg::CH_STAR:  dec_op = iee_pkg::OP_MUL;
			iee_pkg::CH_SLASH: dec_op = iee_pkg::OP_DIV;
			default:           is_op  = 1'b0;
		endcase
	end

	// reduce while the stack top binds at least as tightly
	logic may_reduce;
	assign may_reduce = !stat.op_empty &&
		(stat.op_top == iee_pkg::OP_MUL || stat.op_top == iee_pkg::OP_DIV ||
		 op_q == iee_pkg::OP_ADD || op_q == iee_pkg::OP_SUB);

	always_comb begin
		cmd.cmd = iee_pkg::CMD_NONE;
		cmd.ch  = ch_q;
		cmd.op  = op_q;
		unique case (state_q)
			S_ENDLIT: cmd.cmd = iee_pkg::CMD_END_LIT;
			S_CHECK:  cmd.cmd = may_reduce ? iee_pkg::CMD_NONE :
				(isop_q ? iee_pkg::CMD_PUSH_OP : iee_pkg::CMD_NONE);
			S_RSTART: cmd.cmd = iee_pkg::CMD_RED_START;
			S_MLO:    cmd.cmd = iee_pkg::CMD_MUL_LO;
			S_MHI:    cmd.cmd = iee_pkg::CMD_MUL_HI;
			S_MFIN:   cmd.cmd = iee_pkg::CMD_MUL_FIN;
			S_DIV:    cmd.cmd = iee_pkg::CMD_DIV_STEP;
			S_RWRITE: cmd.cmd = iee_pkg::CMD_RED_WRITE;
			S_FIN:    cmd.cmd = fin_ok ? iee_pkg::CMD_FINISH : iee_pkg::CMD_NONE;
			default:  cmd.cmd = iee_pkg::CMD_NONE;
		endcase
		if (state_q == S_IDLE && in_valid && is_dig) begin
			cmd.cmd = iee_pkg::CMD_DIGIT;
			cmd.ch  = character;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= 1'b0;
			isop_q      <= 1'b0;
			flush_q     <= 1'b0;
			op_q        <= iee_pkg::OP_ADD;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded at finish, emptied by the output transfer
			if (state_q == S_FIN && fin_ok) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ch_q    <= character;
						last_q  <= last;
						isop_q  <= is_op;
						op_q    <= dec_op;
						flush_q <= 1'b0;
						if (is_dig) state_q <= last ? S_ENDLIT : S_IDLE;
						else state_q <= S_ENDLIT;
					end
				end
				S_ENDLIT: begin
					if (isop_q) state_q <= S_CHECK;
					else if (last_q) begin
						flush_q <= 1'b1;
						state_q <= S_FLUSH;
					end else state_q <= S_IDLE;
				end
				S_CHECK: begin
					if (may_reduce) state_q <= S_RSTART;
					else if (last_q) begin
						isop_q  <= 1'b0;
						flush_q <= 1'b1;
						state_q <= S_FLUSH;
					end else state_q <= S_IDLE;
				end
				S_RSTART: begin
					if (!stat.red_valid) state_q <= flush_q ? S_FLUSH : S_CHECK;
					else if (stat.op_top == iee_pkg::OP_MUL) state_q <= S_MLO;
					else if (stat.op_top == iee_pkg::OP_DIV) state_q <= S_DIV;
					else state_q <= S_RWRITE;
				end
				S_MLO:  state_q <= S_MHI;
				S_MHI:  state_q <= S_MFIN;
				S_MFIN: state_q <= S_RWRITE;
				S_DIV: begin
					if (stat.div_done) state_q <= S_RWRITE;
				end
				S_RWRITE: state_q <= flush_q ? S_FLUSH : S_CHECK;
				S_FLUSH: state_q <= stat.op_empty ? S_FIN : S_RSTART;
				S_FIN: begin
					if (fin_ok) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### src/infix_expression_evaluator_top.sv
// Top level of the infix expression evaluator.
//  channel | signals                                   | direction
//  input   | in_valid, in_ready, character, last       | item in
//  output  | out_valid, out_ready, value, overflow,    | result out
//          | div_by_zero, malformed                    |
// A digit is accumulated in the idle state; any other character first closes an
// open literal. An operator is then checked against the operator stack and may
// trigger reductions: add or subtract, multiply, or divide (128 quotient bits,
// one per cycle); a zero divisor or a value stack with fewer than two values
// ends a reduction early. The last character adds the closing reductions, a check
// of the operator stack and the load of the result register. Input is then taken
// again; the finish step stalls only while an earlier result still waits for its
// output transfer. Reset clears the stack counts and internal flags, not the result.
module infix_expression_evaluator_top #(
	parameter int STACK_DEPTH   = iee_pkg::STACK_DEPTH_DEF,
	parameter int FRACTION_BITS = iee_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         character,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] value,
	output logic               overflow,
	output logic               div_by_zero,
	output logic               malformed
);
	iee_pkg::cmd_t  cmd;
	iee_pkg::stat_t stat;

	iee_ctrl u_ctrl (
		.clk, .arst_n, .character, .last, .in_valid, .in_ready,
		.out_valid, .out_ready, .stat, .cmd
	);

	iee_datapath #(
		.STACK_DEPTH(STACK_DEPTH), .FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk, .arst_n, .cmd, .stat,
		.res_value(value), .res_ovf(overflow), .res_div0(div_by_zero),
		.res_mal(malformed)
	);

endmodule
